### design/fexp_pkg.sv
// Shared constants, 2^(i/32) table and types for the float32 exponential.
// No dependencies; imported by the top level and the assertion checker.
package fexp_pkg;

  // Input beat to output beat, in cycles
  localparam int unsigned LAT = 35;

  // binary64 operands (bit patterns)
  localparam logic [63:0] D_INV_LN2_N = 64'h40471547652b82fe;  // 32/ln2
  localparam logic [63:0] D_RND_SHIFT = 64'h4338000000000000;  // 0x1.8p52
  localparam logic [63:0] D_RND_NEG   = 64'hc338000000000000;  // -0x1.8p52
  localparam logic [63:0] D_POLY_A    = 64'h3ebc6af84b912394;
  localparam logic [63:0] D_POLY_B    = 64'h3f2ebfce50fac4f3;
  localparam logic [63:0] D_POLY_C    = 64'h3f962e42ff0c52d6;
  localparam logic [63:0] D_ONE       = 64'h3ff0000000000000;

  // binary32 patterns
  localparam logic [31:0] F_POS_INF  = 32'h7f800000;
  localparam logic [31:0] F_NEG_INF  = 32'hff800000;
  localparam logic [31:0] F_QUIET    = 32'h00400000;
  localparam logic [30:0] F_HI_MAG   = 31'h42b17217;  // 0x1.62e42ep6
  localparam logic [30:0] F_LO_MAG   = 31'h42cff1b4;  // magnitude of -0x1.9fe368p6

  localparam int unsigned IDX_W   = 5;
  localparam int unsigned KLOW_W  = 17;  // low bits of k that reach the scale word
  localparam int unsigned SCALE_SH = 47;

  typedef struct packed {
    logic        hit;
    logic [31:0] val;
  } spec_t;

  function automatic logic [63:0] pow2_frac(input logic [IDX_W-1:0] idx);
    logic [63:0] w;
    case (idx)
      5'd0:  w = 64'h3ff0000000000000;
      5'd1:  w = 64'h3fefd9b0d3158574;
      5'd2:  w = 64'h3fefb5586cf9890f;
      5'd3:  w = 64'h3fef9301d0125b51;
      5'd4:  w = 64'h3fef72b83c7d517b;
      5'd5:  w = 64'h3fef54873168b9aa;
      5'd6:  w = 64'h3fef387a6e756238;
      5'd7:  w = 64'h3fef1e9df51fdee1;
      5'd8:  w = 64'h3fef06fe0a31b715;
      5'd9:  w = 64'h3feef1a7373aa9cb;
      5'd10: w = 64'h3feedea64c123422;
      5'd11: w = 64'h3feece086061892d;
      5'd12: w = 64'h3feebfdad5362a27;
      5'd13: w = 64'h3feeb42b569d4f82;
      5'd14: w = 64'h3feeab07dd485429;
      5'd15: w = 64'h3feea47eb03a5585;
      5'd16: w = 64'h3feea09e667f3bcd;
      5'd17: w = 64'h3fee9f75e8ec5f74;
      5'd18: w = 64'h3feea11473eb0187;
      5'd19: w = 64'h3feea589994cce13;
      5'd20: w = 64'h3feeace5422aa0db;
      5'd21: w = 64'h3feeb737b0cdc5e5;
      5'd22: w = 64'h3feec49182a3f090;
      5'd23: w = 64'h3feed503b23e255d;
      5'd24: w = 64'h3feee89f995ad3ad;
      5'd25: w = 64'h3feeff76f2fb5e47;
      5'd26: w = 64'h3fef199bdd85529c;
      5'd27: w = 64'h3fef3720dcef9069;
      5'd28: w = 64'h3fef5818dcfba487;
      5'd29: w = 64'h3fef7c97337b9b5f;
      5'd30: w = 64'h3fefa4afa2a490da;
      5'd31: w = 64'h3fefd0765b6e4540;
      default: w = 64'h3ff0000000000000;
    endcase
    return w;
  endfunction

endpackage

### design/fexp_dmul.sv
// Three-stage binary64 multiplier, round to nearest even, normal or zero operands.
// Standalone; the whole pipe advances on en_i.
module fexp_dmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [52:0]  ma, mb;
  logic         s1_s_d, s1_zero_d;
  logic [12:0]  s1_e_d;
  logic         s1_s_q, s1_zero_q;
  logic [12:0]  s1_e_q;
  logic [51:0]  hh_d, hh_q;
  logic [52:0]  hl_d, hl_q, lh_d, lh_q;
  logic [53:0]  ll_d, ll_q;

  logic         s2_s_q, s2_zero_q;
  logic [12:0]  s2_e_q;
  logic [105:0] prod_d, prod_q;

  logic [52:0]  mant;
  logic         g, st, up;
  logic [53:0]  m54;
  logic [12:0]  e3;
  logic [51:0]  frac;
  logic [63:0]  p_d, p_q;

  // Stage 1: four partial products (26/27-bit halves)
  always_comb begin
    ma        = {1'b1, a_i[51:0]};
    mb        = {1'b1, b_i[51:0]};
    s1_s_d    = a_i[63] ^ b_i[63];
    s1_zero_d = (a_i[62:52] == 11'd0) || (b_i[62:52] == 11'd0);
    s1_e_d    = 13'(a_i[62:52]) + 13'(b_i[62:52]) - 13'd1023;
    hh_d      = ma[52:27] * mb[52:27];
    hl_d      = ma[52:27] * mb[26:0];
    lh_d      = ma[26:0]  * mb[52:27];
    ll_d      = ma[26:0]  * mb[26:0];
  end

  // Stage 2: sum of partials
  assign prod_d = (106'(hh_q) << 54) + (106'(hl_q) << 27) + (106'(lh_q) << 27) + 106'(ll_q);

  // Stage 3: normalize and round
  always_comb begin
    e3 = s2_e_q;
    if (prod_q[105]) begin
      mant = prod_q[105:53];
      g    = prod_q[52];
      st   = |prod_q[51:0];
      e3   = e3 + 13'd1;
    end else begin
      mant = prod_q[104:52];
      g    = prod_q[51];
      st   = |prod_q[50:0];
    end
    up  = g & (st | mant[0]);
    m54 = {1'b0, mant} + 54'(up);
    if (m54[53]) begin
      e3   = e3 + 13'd1;
      frac = '0;
    end else begin
      frac = m54[51:0];
    end
    p_d = s2_zero_q ? {s2_s_q, 63'd0} : {s2_s_q, e3[10:0], frac};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_s_q    <= s1_s_d;
      s1_zero_q <= s1_zero_d;
      s1_e_q    <= s1_e_d;
      hh_q      <= hh_d;
      hl_q      <= hl_d;
      lh_q      <= lh_d;
      ll_q      <= ll_d;
      s2_s_q    <= s1_s_q;
      s2_zero_q <= s1_zero_q;
      s2_e_q    <= s1_e_q;
      prod_q    <= prod_d;
      p_q       <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### design/fexp_dadd.sv
// Four-stage binary64 adder, round to nearest even, normal or zero operands.
// Standalone; the whole pipe advances on en_i.
module fexp_dadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] s_o
);

  logic        a_big;
  logic [52:0] ma, mb;
  logic [10:0] dexp;
  logic        s1_s_d, s1_sub_d;
  logic [10:0] s1_e_d;
  logic [52:0] s1_mb_d, s1_ms_d;
  logic [5:0]  s1_d_d;
  logic        s1_s_q, s1_sub_q;
  logic [10:0] s1_e_q;
  logic [52:0] s1_mb_q, s1_ms_q;
  logic [5:0]  s1_d_q;

  logic [55:0] big_ext, small_ext, shifted, lost, al;
  logic [56:0] sum_d, sum_q;
  logic        s2_s_q, s2_sub_q;
  logic [12:0] s2_e_q;

  logic [5:0]  msb, lz;
  logic [55:0] nm_d, nm_q;
  logic [12:0] e3_d, e3_q;
  logic        zero_d, zero_q, s3_s_q, s3_sub_q;

  logic        g, st, up;
  logic [53:0] m54;
  logic [12:0] e4;
  logic [51:0] frac;
  logic [63:0] s_d, s_q;

  // Stage 1: order by magnitude, exponent difference
  always_comb begin
    ma    = (a_i[62:52] == 11'd0) ? 53'd0 : {1'b1, a_i[51:0]};
    mb    = (b_i[62:52] == 11'd0) ? 53'd0 : {1'b1, b_i[51:0]};
    a_big = a_i[62:0] >= b_i[62:0];
    s1_sub_d = a_i[63] ^ b_i[63];
    if (a_big) begin
      s1_s_d  = a_i[63];
      s1_e_d  = a_i[62:52];
      s1_mb_d = ma;
      s1_ms_d = mb;
      dexp    = a_i[62:52] - b_i[62:52];
    end else begin
      s1_s_d  = b_i[63];
      s1_e_d  = b_i[62:52];
      s1_mb_d = mb;
      s1_ms_d = ma;
      dexp    = b_i[62:52] - a_i[62:52];
    end
    s1_d_d = (dexp > 11'd63) ? 6'd63 : dexp[5:0];
  end

  // Stage 2: align with guard/round/sticky, add or subtract
  always_comb begin
    big_ext   = {s1_mb_q, 3'b000};
    small_ext = {s1_ms_q, 3'b000};
    shifted   = small_ext >> s1_d_q;
    lost      = small_ext & ~({56{1'b1}} << s1_d_q);
    al        = shifted | 56'(|lost);
    sum_d     = s1_sub_q ? ({1'b0, big_ext} - {1'b0, al}) : ({1'b0, big_ext} + {1'b0, al});
  end

  // Stage 3: normalize
  always_comb begin
    msb = '0;
    for (int i = 0; i < 56; i++) begin
      if (sum_q[i]) msb = 6'(i);
    end
    lz     = 6'd55 - msb;
    zero_d = (sum_q == '0);
    if (sum_q[56]) begin
      nm_d = {sum_q[56:2], sum_q[1] | sum_q[0]};
      e3_d = s2_e_q + 13'd1;
    end else begin
      nm_d = sum_q[55:0] << lz;
      e3_d = s2_e_q - 13'(lz);
    end
  end

  // Stage 4: round and pack; exact cancellation gives +0
  always_comb begin
    g   = nm_q[2];
    st  = nm_q[1] | nm_q[0];
    up  = g & (st | nm_q[3]);
    m54 = {1'b0, nm_q[55:3]} + 54'(up);
    e4  = e3_q;
    if (m54[53]) begin
      e4   = e4 + 13'd1;
      frac = '0;
    end else begin
      frac = m54[51:0];
    end
    s_d = zero_q ? {s3_s_q & ~s3_sub_q, 63'd0} : {s3_s_q, e4[10:0], frac};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_s_q   <= s1_s_d;
      s1_sub_q <= s1_sub_d;
      s1_e_q   <= s1_e_d;
      s1_mb_q  <= s1_mb_d;
      s1_ms_q  <= s1_ms_d;
      s1_d_q   <= s1_d_d;
      sum_q    <= sum_d;
      s2_s_q   <= s1_s_q;
      s2_sub_q <= s1_sub_q;
      s2_e_q   <= 13'(s1_e_q);
      nm_q     <= nm_d;
      e3_q     <= e3_d;
      zero_q   <= zero_d;
      s3_s_q   <= s2_s_q;
      s3_sub_q <= s2_sub_q;
      s_q      <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

### design/float32_exp_exact.sv
// float32 exponential, bit exact.
// Throughput one beat per cycle unless the output stalls; the whole pipe advances
// whenever the output register is empty or being drained, so in_ready_o follows
// out_ready_i. The datapath is a chain of binary64 units in series: 4 multiplies
// and 5 adds, plus the input register and two rounding stages.
// Reset clears only the valid bits; no clearing pass.
module float32_exp_exact
  import fexp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] y_bits_o
);

  localparam int unsigned Z_DLY  = 8;   // z waits for kb
  localparam int unsigned K_DLY  = 22;  // k waits for the polynomial
  localparam int unsigned R2_DLY = 4;   // r*r waits for zz
  localparam int unsigned Y1_DLY = 3;   // y1 waits for p3
  localparam int unsigned SP_DLY = LAT - 1;

  logic en;
  logic [LAT-1:0] v_q;

  // ---- Input stage: specials and float -> double ----
  spec_t       spec_d;
  logic [63:0] xd_d, xd_q;
  logic [4:0]  p;
  logic [52:0] sub_w;
  logic        xs;
  logic [7:0]  xe;
  logic [22:0] xf;

  always_comb begin
    xs = x_bits_i[31];
    xe = x_bits_i[30:23];
    xf = x_bits_i[22:0];
    spec_d.hit = 1'b1;
    spec_d.val = '0;
    if (xe == 8'hff) begin
      if (x_bits_i == F_NEG_INF) spec_d.val = '0;
      else if (xf != 23'd0)      spec_d.val = x_bits_i | F_QUIET;  // quiet NaN
      else                       spec_d.val = x_bits_i;
    end else if (!xs && (x_bits_i[30:0] > F_HI_MAG)) begin
      spec_d.val = F_POS_INF;
    end else if (xs && (x_bits_i[30:0] > F_LO_MAG)) begin
      spec_d.val = '0;
    end else begin
      spec_d.hit = 1'b0;
    end

    // subnormal: locate leading one
    p = '0;
    for (int i = 0; i < 23; i++) begin
      if (xf[i]) p = 5'(i);
    end
    sub_w = 53'(xf) << (6'd52 - 6'(p));

    if (xe != 8'd0)       xd_d = {xs, 11'(xe) + 11'd896, xf, 29'd0};
    else if (xf != 23'd0) xd_d = {xs, 11'(p) + 11'd874, sub_w[51:0]};
    else                  xd_d = {xs, 63'd0};
  end

  // ---- binary64 core ----
  logic [63:0] z, kd, kb, r, p1, r2, p2, zz, y1, p3, yd, ys;
  logic [63:0] kb_neg, sbits;
  logic [63:0] z_dly_q  [Z_DLY];
  logic [KLOW_W-1:0] k_dly_q [K_DLY];
  logic [63:0] r2_dly_q [R2_DLY];
  logic [63:0] y1_dly_q [Y1_DLY];
  spec_t       sp_dly_q [SP_DLY];

  fexp_dmul u_mul_z  (.clk_i, .en_i(en), .a_i(xd_q), .b_i(D_INV_LN2_N), .p_o(z));
  // kd = z + 1.5*2^52 rounds z to the integer k
  fexp_dadd u_add_kd (.clk_i, .en_i(en), .a_i(z),  .b_i(D_RND_SHIFT), .s_o(kd));
  fexp_dadd u_add_kb (.clk_i, .en_i(en), .a_i(kd), .b_i(D_RND_NEG),   .s_o(kb));
  assign kb_neg = {~kb[63], kb[62:0]};
  fexp_dadd u_add_r  (.clk_i, .en_i(en), .a_i(z_dly_q[Z_DLY-1]), .b_i(kb_neg), .s_o(r));

  fexp_dmul u_mul_p1 (.clk_i, .en_i(en), .a_i(D_POLY_A), .b_i(r), .p_o(p1));
  fexp_dmul u_mul_r2 (.clk_i, .en_i(en), .a_i(r),        .b_i(r), .p_o(r2));
  fexp_dmul u_mul_p2 (.clk_i, .en_i(en), .a_i(D_POLY_C), .b_i(r), .p_o(p2));
  fexp_dadd u_add_zz (.clk_i, .en_i(en), .a_i(p1), .b_i(D_POLY_B), .s_o(zz));
  fexp_dadd u_add_y1 (.clk_i, .en_i(en), .a_i(p2), .b_i(D_ONE),    .s_o(y1));
  fexp_dmul u_mul_p3 (.clk_i, .en_i(en), .a_i(zz), .b_i(r2_dly_q[R2_DLY-1]), .p_o(p3));
  fexp_dadd u_add_y  (.clk_i, .en_i(en), .a_i(p3), .b_i(y1_dly_q[Y1_DLY-1]), .s_o(yd));

  // scale 2^(k/32): table word plus high part of k into the exponent field
  assign sbits = pow2_frac(k_dly_q[K_DLY-1][IDX_W-1:0])
               + {k_dly_q[K_DLY-1], SCALE_SH'(0)};
  fexp_dmul u_mul_s  (.clk_i, .en_i(en), .a_i(yd), .b_i(sbits), .p_o(ys));

  // ---- double -> float, RNE with subnormals ----
  logic [11:0] ef;
  logic [52:0] m, mm, lost;
  logic [5:0]  sh;
  logic [7:0]  fe;
  logic        f1_inf_d, f1_g_d, f1_st_d;
  logic [30:0] f1_base_d;
  logic        f1_inf_q, f1_g_q, f1_st_q;
  logic [30:0] f1_base_q;
  logic        up;
  logic [31:0] y_d, y_q;

  always_comb begin
    ef   = 12'(ys[62:52]) - 12'd896;
    m    = {1'b1, ys[51:0]};
    sh   = '0;
    mm   = m;
    lost = '0;
    fe   = '0;
    f1_inf_d = 1'b0;
    if (!ef[11] && (ef != 12'd0)) begin
      if (ef >= 12'd255) f1_inf_d = 1'b1;
      fe = ef[7:0];
    end else begin
      sh   = ((12'd1 - ef) > 12'd63) ? 6'd63 : 6'(12'd1 - ef);
      mm   = m >> sh;
      lost = m & ~({53{1'b1}} << sh);
    end
    f1_base_d = {fe, mm[51:29]};
    f1_g_d    = mm[28];
    f1_st_d   = (|mm[27:0]) | (|lost);
  end

  always_comb begin
    up = f1_g_q & (f1_st_q | f1_base_q[0]);
    // carry out of the fraction moves into the exponent (and up to inf)
    y_d = f1_inf_q ? F_POS_INF : {1'b0, f1_base_q + 31'(up)};
    if (sp_dly_q[SP_DLY-1].hit) y_d = sp_dly_q[SP_DLY-1].val;
  end

  // ---- flow control ----
  assign en          = out_ready_i | ~v_q[LAT-1];
  assign in_ready_o  = en;
  assign out_valid_o = v_q[LAT-1];
  assign y_bits_o    = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q        <= xd_d;
      z_dly_q[0]  <= z;
      k_dly_q[0]  <= kd[KLOW_W-1:0];
      r2_dly_q[0] <= r2;
      y1_dly_q[0] <= y1;
      sp_dly_q[0] <= spec_d;
      for (int i = 1; i < Z_DLY; i++)  z_dly_q[i]  <= z_dly_q[i-1];
      for (int i = 1; i < K_DLY; i++)  k_dly_q[i]  <= k_dly_q[i-1];
      for (int i = 1; i < R2_DLY; i++) r2_dly_q[i] <= r2_dly_q[i-1];
      for (int i = 1; i < Y1_DLY; i++) y1_dly_q[i] <= y1_dly_q[i-1];
      for (int i = 1; i < SP_DLY; i++) sp_dly_q[i] <= sp_dly_q[i-1];
      f1_inf_q  <= f1_inf_d;
      f1_base_q <= f1_base_d;
      f1_g_q    <= f1_g_d;
      f1_st_q   <= f1_st_d;
      y_q       <= y_d;
    end
  end

endmodule

### design/float32_exp_exact_chk.sv
// Port-level checker for float32_exp_exact, bound to every instance.
// Depends on fexp_pkg for float constants.
module float32_exp_exact_chk
  import fexp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] x_bits_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] y_bits_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_bits_o))
    else $error("output beat changed under stall");

  // input side stalls only when the output is full and blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (out_ready_i || !out_valid_o))
    else $error("ready does not track output side");

  // exp is never negative except for a NaN result
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && y_bits_o[31] |-> (y_bits_o[30:23] == 8'hff) && (y_bits_o[22:0] != 23'd0))
    else $error("negative non-NaN result");

  // any NaN result is quiet
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (y_bits_o[30:23] == 8'hff) && (y_bits_o[22:0] != 23'd0)
      |-> (y_bits_o & F_QUIET) != 32'd0)
    else $error("signaling NaN result");

  // pipe is empty right after reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind float32_exp_exact float32_exp_exact_chk u_chk (.*);

### tb/tb_float32_exp_exact.sv
// Self-checking testbench for float32_exp_exact: directed table, then random beats.
// Depends on fexp_pkg (latency, binary64 constants) and the float32_exp_exact RTL.
module tb_float32_exp_exact
  import fexp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RAND     = 700;
  localparam int unsigned HOLD_CYC   = 300;   // long receiver hold-off
  localparam int unsigned IDLE_PCT   = 10;
  localparam int unsigned MAX_REPORT = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] x_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] y_bits_o;

  float32_exp_exact dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_bits_i   (x_bits_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .y_bits_o   (y_bits_o)
  );

  // Expected results, oldest first
  logic [31:0] exp_y_q[$];
  int unsigned n_err;
  int unsigned n_in;
  int unsigned n_out;
  bit          quiet;      // no idling on either side
  bit          hold_go;    // request one long receiver hold-off
  bit          hold_taken;

  // 2^(i/32) as binary64 words
  logic [63:0] frac_tab [32] = '{
    64'h3ff0000000000000, 64'h3fefd9b0d3158574, 64'h3fefb5586cf9890f,
    64'h3fef9301d0125b51, 64'h3fef72b83c7d517b, 64'h3fef54873168b9aa,
    64'h3fef387a6e756238, 64'h3fef1e9df51fdee1, 64'h3fef06fe0a31b715,
    64'h3feef1a7373aa9cb, 64'h3feedea64c123422, 64'h3feece086061892d,
    64'h3feebfdad5362a27, 64'h3feeb42b569d4f82, 64'h3feeab07dd485429,
    64'h3feea47eb03a5585, 64'h3feea09e667f3bcd, 64'h3fee9f75e8ec5f74,
    64'h3feea11473eb0187, 64'h3feea589994cce13, 64'h3feeace5422aa0db,
    64'h3feeb737b0cdc5e5, 64'h3feec49182a3f090, 64'h3feed503b23e255d,
    64'h3feee89f995ad3ad, 64'h3feeff76f2fb5e47, 64'h3fef199bdd85529c,
    64'h3fef3720dcef9069, 64'h3fef5818dcfba487, 64'h3fef7c97337b9b5f,
    64'h3fefa4afa2a490da, 64'h3fefd0765b6e4540
  };

  // Exact binary32 -> binary64 widening, subnormals normalized
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [23:0] m;
    int          e;
    m = {1'b0, f[22:0]};
    if (f[30:0] == 31'd0) return {f[31], 63'd0};
    if (f[30:23] == 8'd0) begin
      e = -126;
      while (!m[23]) begin
        m = m << 1;
        e = e - 1;
      end
    end else begin
      e = int'(f[30:23]) - 127;
      m[23] = 1'b1;
    end
    return {f[31], 11'(e + 1023), m[22:0], 29'd0};
  endfunction

  // binary64 -> binary32, round to nearest even, subnormals and overflow
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic [63:0] sig, q, rem, half, v;
    int          ef, sh;
    if (d[62:52] == 11'h7ff) return {d[63], 8'hff, 23'd0};
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    if (d[62:52] == 11'd0) begin
      sig = {12'd0, d[51:0]};
      ef  = -1022 + 127;
    end else begin
      sig = {11'd0, 1'b1, d[51:0]};
      ef  = int'(d[62:52]) - 1023 + 127;
    end
    sh = (ef >= 1) ? 29 : 29 + (1 - ef);
    if (sh > 54) return {d[63], 31'd0};
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (ef >= 1) v = (64'(ef) << 23) + q - (64'd1 << 23);
    else         v = q;
    if (v >= (64'd255 << 23)) return {d[63], 8'hff, 23'd0};
    return {d[63], v[30:0]};
  endfunction

  // Table-driven exp for a finite argument inside the thresholds
  function automatic logic [31:0] exp_core_f32(input logic [31:0] x);
    real         z, kd, kb, r, r2, p1, zz, p2, y1, p3, y, sd;
    logic [63:0] kbits, sbits;
    z     = $bitstoreal(widen_f32(x)) * $bitstoreal(D_INV_LN2_N);
    kd    = z + $bitstoreal(D_RND_SHIFT);
    kbits = $realtobits(kd);
    sbits = frac_tab[kbits[4:0]] + (kbits << 47);
    sd    = $bitstoreal(sbits);
    kb    = kd - $bitstoreal(D_RND_SHIFT);
    r     = z - kb;
    p1    = $bitstoreal(D_POLY_A) * r;
    zz    = p1 + $bitstoreal(D_POLY_B);
    r2    = r * r;
    p2    = $bitstoreal(D_POLY_C) * r;
    y1    = p2 + 1.0;
    p3    = zz * r2;
    y     = p3 + y1;
    y     = y * sd;
    return narrow_f64($realtobits(y));
  endfunction

  function automatic logic [31:0] predict_exp(input logic [31:0] x);
    if (x[30:23] == 8'hff) begin
      if (x == F_NEG_INF)      return 32'h0;
      if (x[22:0] != 23'd0)    return x | F_QUIET;   // NaN is quieted
      return x;                                     // +inf
    end
    if (!x[31] && x[30:0] > F_HI_MAG) return F_POS_INF;
    if (x[31] && x[30:0] > F_LO_MAG)  return 32'h0;
    return exp_core_f32(x);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #3ms;
    $display("timeout: %0d beats in, %0d out, %0d pending", n_in, n_out, exp_y_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: checks are taken at the falling edge, where every signal is settled;
  // the beat itself completes at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (exp_y_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORT)
          $display("unexpected result beat y=%h", y_bits_o);
      end else begin
        logic [31:0] want;
        want = exp_y_q.pop_front();
        if (y_bits_o !== want) begin
          n_err++;
          if (n_err <= MAX_REPORT)
            $display("mismatch: y expected %h actual %h", want, y_bits_o);
        end
      end
    end
  end

  // Receiver ready: random back-pressure, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_taken  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else begin
        out_ready_i <= (!quiet && $urandom_range(0, 99) < IDLE_PCT) ? 1'b0 : 1'b1;
      end
    end
  end

  // Offer one beat, hold it until accepted, record what it should produce.
  // known: the table already gives the answer.
  task automatic send_beat(input logic [31:0] x, input bit known, input logic [31:0] y);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 50);
    end
    in_valid_i <= 1'b1;
    x_bits_i   <= x;
    do @(negedge clk_i); while (!in_ready_o);
    exp_y_q.push_back(known ? y : predict_exp(x));
    n_in++;
    @(posedge clk_i);
  endtask

  // Random argument: mostly in the working range, some near the thresholds,
  // the rest any 32-bit pattern.
  function automatic logic [31:0] rand_arg();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return {1'($urandom), 8'($urandom_range(100, 133)), 23'($urandom)};
    if (sel < 75) begin
      if ($urandom_range(0, 1))
        return {1'b0, F_HI_MAG + 31'($urandom_range(0, 8)) - 31'd4};
      return {1'b1, F_LO_MAG + 31'($urandom_range(0, 8)) - 31'd4};
    end
    return $urandom;
  endfunction

  typedef struct {
    logic [31:0] x;
    bit          known;
    logic [31:0] y;
  } dir_row_t;

  dir_row_t dir_tab [21];

  initial begin
    dir_tab = '{
      '{32'h00000000, 1'b1, 32'h3f800000},   // +0
      '{32'h80000000, 1'b1, 32'h3f800000},   // -0
      '{32'h7f800000, 1'b1, 32'h7f800000},   // +inf
      '{32'hff800000, 1'b1, 32'h00000000},   // -inf
      '{32'h7fc00000, 1'b1, 32'h7fc00000},   // quiet NaN
      '{32'h7f800001, 1'b1, 32'h7fc00001},   // signaling NaN gets quieted
      '{32'hffa00000, 1'b1, 32'hffe00000},   // negative NaN
      '{32'h7fffffff, 1'b1, 32'h7fffffff},
      '{32'h42b17218, 1'b1, 32'h7f800000},   // just above upper threshold
      '{32'hc2cff1b5, 1'b1, 32'h00000000},   // just below lower threshold
      '{32'h7f7fffff, 1'b1, 32'h7f800000},   // max finite
      '{32'hff7fffff, 1'b1, 32'h00000000},   // most negative finite
      '{32'h42b17217, 1'b0, 32'h0},          // upper threshold itself
      '{32'hc2cff1b4, 1'b0, 32'h0},          // lower threshold itself
      '{32'h00000001, 1'b0, 32'h0},          // subnormal arguments
      '{32'h80000001, 1'b0, 32'h0},
      '{32'h007fffff, 1'b0, 32'h0},
      '{32'h3f800000, 1'b0, 32'h0},          // 1.0
      '{32'hbf800000, 1'b0, 32'h0},          // -1.0
      '{32'hc2b00000, 1'b0, 32'h0},          // -88: subnormal result
      '{32'hc2c80000, 1'b0, 32'h0}           // -100: deep subnormal result
    };
  end

  // Main sequence
  initial begin
    int unsigned wait_cyc;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    x_bits_i   = 32'h0;
    quiet      = 1'b0;
    hold_go    = 1'b0;
    n_err      = 0;
    n_in       = 0;
    n_out      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].x, dir_tab[i].known, dir_tab[i].y);

    for (int unsigned i = 0; i < N_RAND; i++) begin
      // receiver stalls long while beats keep coming: the pipe fills up
      if (i == 200) hold_go = 1'b1;
      // sender drains the pipe completely before going on
      if (i == 400) begin
        in_valid_i <= 1'b0;
        while (exp_y_q.size() != 0) @(posedge clk_i);
      end
      quiet = (i >= 450 && i < 570);
      send_beat(rand_arg(), 1'b0, 32'h0);
    end
    in_valid_i <= 1'b0;

    wait_cyc = 0;
    while (exp_y_q.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (LAT + 10) @(posedge clk_i);
    if (exp_y_q.size() != 0) begin
      n_err++;
      $display("%0d expected results never arrived", exp_y_q.size());
    end

    $display("covered %0d arguments (%0d directed: zeros, infinities, NaNs, thresholds,",
             n_in, $size(dir_tab));
    $display("  subnormals), %0d results checked, %0d mismatches", n_out, n_err);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### float32_exp_exact.f
design/fexp_pkg.sv
design/fexp_dmul.sv
design/fexp_dadd.sv
design/float32_exp_exact.sv
design/float32_exp_exact_chk.sv
tb/tb_float32_exp_exact.sv
